/* rtl/core/tbb_pkg.sv */
// Shared widths, reset values and payload types for the box transform pipeline.
package tbb_pkg;

	localparam int CW   = 32;  // coordinate width
	localparam int FB   = 16;  // fraction bits
	localparam int MW   = 32;  // matrix entry width
	localparam int NREG = 8;
	localparam int IW   = 8;   // configuration index width
	localparam int RW   = 64;  // configuration register width
	localparam int PW   = CW + MW;
	localparam int SW   = ((CW > FB) ? CW : FB) + MW + 2;
	localparam int NW   = SW + FB;
	localparam int XW   = SW + CW - 1;
	localparam int QW   = CW - 1;

	localparam logic [NREG-1:0][RW-1:0] REG_RESET = {
		RW'(1) << (32 + FB), RW'(0), RW'(1) << FB, RW'(0),
		RW'(0), RW'(1) << (32 + FB), RW'(0), RW'(1) << FB
	};

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	typedef struct packed {
		coord_t out_min_x;
		coord_t out_min_y;
		coord_t out_min_z;
		coord_t out_max_x;
		coord_t out_max_y;
		coord_t out_max_z;
		logic   w_fault;
	} res_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QW-1:0] q;
		logic          nneg;
		logic          nzero;
		logic          sat;
	} ax_t;

	typedef struct packed {
		logic          valid;
		logic          last;
		logic [SW-1:0] d;
		logic          dneg;
		logic          dzero;
		ax_t [2:0]     ax;
	} dstage_t;

endpackage

/* rtl/core/tbb_if.sv */
// Handshake channels for boxes in and transformed boxes out.
interface tbb_box_if import tbb_pkg::*; ();
	logic valid;
	logic ready;
	box_t box;
	modport source (output valid, output box, input ready);
	modport sink (input valid, input box, output ready);
endinterface

interface tbb_res_if import tbb_pkg::*; ();
	logic valid;
	logic ready;
	res_t res;
	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

/* rtl/core/transform_bounding_box.sv */
// Top level: box through a 4x4 homogeneous matrix, one corner per cycle unless stalled.
//
//  channel   | dir | payload                          | handshake
//  box_in    | in  | min_x..max_z                     | valid/ready
//  box_out   | out | out_min_x..out_max_z, w_fault    | valid/ready
//  cfg       | in  | cfg_index, cfg_data              | cfg_we
//
// A box is taken as eight corners: the corner sequencer issues one corner per cycle,
// unless the pipeline stalls, into the multiply, sum and divide pipeline, whose
// divider resolves one quotient bit per stage.
// Reset loads the identity matrix and empties the pipeline.
// The pipeline only stalls when a finished box meets a full output register.
module transform_bounding_box import tbb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [IW-1:0] cfg_index,
	input  logic [RW-1:0] cfg_data,
	tbb_box_if.sink       box_in,
	tbb_res_if.source     box_out
);

	logic [NREG-1:0][RW-1:0] cfg_q;
	logic signed [MW-1:0]    mat [4][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= REG_RESET;
		end else if (cfg_we && cfg_index < IW'(NREG)) begin
			cfg_q[cfg_index[$clog2(NREG)-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = cfg_q[3'(r * 2 + (c >> 1))][(c & 1) * MW +: MW];
			end
		end
	end

	// Corner sequencer.
	box_t       box_q;
	logic [2:0] k_q;
	logic       busy_q;
	logic       adv;
	logic       take;
	coord_t     cor [3];

	assign box_in.ready = adv && (!busy_q || k_q == 3'd7);
	assign take = box_in.valid && box_in.ready;

	always_comb begin
		cor[0] = k_q[0] ? box_q.max_x : box_q.min_x;
		cor[1] = k_q[1] ? box_q.max_y : box_q.min_y;
		cor[2] = k_q[2] ? box_q.max_z : box_q.min_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			busy_q <= 1'b0;
		end else if (adv) begin
			if (take) begin
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			box_q <= box_in.box;
		end
	end

	// Stage 1: corner, stage 2: products, stage 3: row sums, stage 4: magnitudes.
	logic                 v_s1, last_s1, v_s2, last_s2, v_s3, last_s3, v_s4, last_s4;
	coord_t               pt_s1 [3];
	logic signed [PW-1:0] prod_s2 [4][3];
	logic signed [SW-1:0] sum_s3 [4];
	logic [SW-1:0]        nmag_s4 [3];
	logic [2:0]           nneg_s4;
	logic [SW-1:0]        dmag_s4;
	logic                 dneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= (k_q == 3'd7);
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int a = 0; a < 3; a++) begin
				pt_s1[a] <= cor[a];
			end
			for (int r = 0; r < 4; r++) begin
				for (int a = 0; a < 3; a++) begin
					prod_s2[r][a] <= mat[r][a] * pt_s1[a];
				end
				sum_s3[r] <= SW'(prod_s2[r][0]) + SW'(prod_s2[r][1]) + SW'(prod_s2[r][2])
					+ (SW'(mat[r][3]) <<< FB);
			end
			for (int a = 0; a < 3; a++) begin
				nmag_s4[a] <= sum_s3[a][SW-1] ? SW'(-sum_s3[a]) : SW'(sum_s3[a]);
				nneg_s4[a] <= sum_s3[a][SW-1];
			end
			dmag_s4 <= sum_s3[3][SW-1] ? SW'(-sum_s3[3]) : SW'(sum_s3[3]);
			dneg_s4 <= sum_s3[3][SW-1];
		end
	end

	// Divider: entry stage checks saturation, then one quotient bit per stage.
	dstage_t div_s5 [QW+1];
	dstage_t div_in;

	function automatic dstage_t div_step(dstage_t s, int i);
		dstage_t        r;
		logic [XW-1:0]  dsh;
		logic [XW-1:0]  rx;
		r = s;
		dsh = XW'(s.d) << i;
		for (int a = 0; a < 3; a++) begin
			rx = XW'(s.ax[a].rem);
			if (rx >= dsh) begin
				r.ax[a].rem  = NW'(rx - dsh);
				r.ax[a].q[i] = 1'b1;
			end
		end
		return r;
	endfunction

	always_comb begin
		div_in       = '0;
		div_in.valid = v_s4;
		div_in.last  = last_s4;
		div_in.d     = dmag_s4;
		div_in.dneg  = dneg_s4;
		div_in.dzero = (dmag_s4 == '0);
		for (int a = 0; a < 3; a++) begin
			div_in.ax[a].rem   = NW'(nmag_s4[a]) << FB;
			div_in.ax[a].nneg  = nneg_s4[a];
			div_in.ax[a].nzero = (nmag_s4[a] == '0);
			// Quotient of 2^(CW-1) or more saturates either way.
			div_in.ax[a].sat   = (XW'(nmag_s4[a]) << FB) >= (XW'(dmag_s4) << (CW - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s5[0] <= '0;
		end else if (adv) begin
			div_s5[0] <= div_in;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s5[j+1] <= '0;
			end else if (adv) begin
				div_s5[j+1] <= div_step(div_s5[j], QW - 1 - j);
			end
		end
	end

	// Stage 6: sign, saturation and the zero-w case.
	function automatic coord_t div_final(ax_t x, logic dneg, logic dzero);
		logic   neg;
		coord_t qv;
		neg = x.nneg ^ dneg;
		qv  = {1'b0, x.q};
		if (dzero) begin
			return x.nzero ? '0 : (x.nneg ? COORD_MIN : COORD_MAX);
		end
		if (x.sat) begin
			return neg ? COORD_MIN : COORD_MAX;
		end
		return neg ? -qv : qv;
	endfunction

	logic   v_s6, last_s6, fault_s6;
	coord_t val_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= div_s5[QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s6  <= div_s5[QW].last;
			fault_s6 <= div_s5[QW].dzero;
			for (int a = 0; a < 3; a++) begin
				val_s6[a] <= div_final(div_s5[QW].ax[a], div_s5[QW].dneg, div_s5[QW].dzero);
			end
		end
	end

	// Running minimum and maximum over the eight corners of a box.
	coord_t mn_q [3];
	coord_t mx_q [3];
	coord_t nmn [3];
	coord_t nmx [3];
	logic   fault_q, first_q, nfault, o_valid_q;
	res_t   res_q;

	assign adv = !(v_s6 && last_s6 && o_valid_q && !box_out.ready);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nmn[a] = (first_q || val_s6[a] < mn_q[a]) ? val_s6[a] : mn_q[a];
			nmx[a] = (first_q || val_s6[a] > mx_q[a]) ? val_s6[a] : mx_q[a];
		end
		nfault = (!first_q && fault_q) || fault_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 1'b1;
			o_valid_q <= 1'b0;
		end else begin
			if (adv && v_s6) begin
				first_q <= last_s6;
			end
			if (adv && v_s6 && last_s6) begin
				o_valid_q <= 1'b1;
			end else if (box_out.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			if (last_s6) begin
				res_q <= '{out_min_x: nmn[0], out_min_y: nmn[1], out_min_z: nmn[2],
					out_max_x: nmx[0], out_max_y: nmx[1], out_max_z: nmx[2],
					w_fault: nfault};
			end else begin
				for (int a = 0; a < 3; a++) begin
					mn_q[a] <= nmn[a];
					mx_q[a] <= nmx[a];
				end
				fault_q <= nfault;
			end
		end
	end

	assign box_out.valid = o_valid_q;
	assign box_out.res   = res_q;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> k_q == 3'd0)
		else $error("corner count not at zero while sequencer idle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(k_q) && $stable(busy_q))
		else $error("corner sequencer moved during a stall");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_s5[QW].valid && !div_s5[QW].dzero |->
			XW'(div_s5[QW].ax[0].rem) < XW'(div_s5[QW].d) || div_s5[QW].ax[0].sat)
		else $error("divider remainder not below divisor");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> res_q.out_min_x <= res_q.out_max_x
			&& res_q.out_min_y <= res_q.out_max_y && res_q.out_min_z <= res_q.out_max_z)
		else $error("result minimum above maximum");

endmodule

/* tb/tb_transform_bounding_box.sv */
// Testbench for the box transform: random and directed boxes checked against a predictor.
`timescale 1ns / 100ps

module tb_transform_bounding_box;
	import tbb_pkg::*;

	localparam int REG_ROW0_LEFT  = 0;
	localparam int REG_ROW0_RIGHT = 1;
	localparam int REG_ROW1_LEFT  = 2;
	localparam int REG_ROW1_RIGHT = 3;
	localparam int REG_ROW2_LEFT  = 4;
	localparam int REG_ROW2_RIGHT = 5;
	localparam int REG_ROW3_LEFT  = 6;
	localparam int REG_ROW3_RIGHT = 7;
	localparam int REG_BEYOND     = 9;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IW-1:0] cfg_index;
	logic [RW-1:0] cfg_data;

	tbb_box_if box_in ();
	tbb_res_if box_out ();

	transform_bounding_box dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .box_in(box_in.sink), .box_out(box_out.source)
	);

	logic [RW-1:0] matrix_regs [NREG];
	box_t pending_boxes [$];
	res_t expected_boxes [$];
	int errors = 0;
	int boxes_sent = 0;
	int boxes_checked = 0;
	int faults_seen = 0;
	bit idle_on = 1;
	bit hold_out = 0;
	int hold_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] entry_of(int r, int c);
		logic [RW-1:0] word;
		word = matrix_regs[r * 2 + c / 2];
		return (c % 2) ? 64'(signed'(word[63:32])) : 64'(signed'(word[31:0]));
	endfunction

	// Exact truncating division with saturation; zero w saturates by numerator sign.
	function automatic coord_t project_axis(logic signed [127:0] num,
			logic signed [127:0] den, ref bit fault);
		logic signed [127:0] q;
		if (den == 0) begin
			fault = 1;
			if (num == 0) return '0;
			return (num < 0) ? COORD_MIN : COORD_MAX;
		end
		q = (num <<< FB) / den;
		if (q > 128'(signed'(COORD_MAX))) return COORD_MAX;
		if (q < 128'(signed'(COORD_MIN))) return COORD_MIN;
		return coord_t'(q);
	endfunction

	function automatic res_t transform_box(box_t b);
		res_t r;
		logic signed [63:0] lo [3];
		logic signed [63:0] hi [3];
		logic signed [63:0] p [4];
		logic signed [127:0] acc [4];
		coord_t v;
		coord_t bmin [3];
		coord_t bmax [3];
		bit fault;
		fault = 0;
		lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
		hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
		for (int k = 0; k < 8; k++) begin
			for (int a = 0; a < 3; a++) p[a] = k[a] ? hi[a] : lo[a];
			p[3] = 64'sd1 <<< FB;
			for (int row = 0; row < 4; row++) begin
				acc[row] = 0;
				for (int a = 0; a < 4; a++)
					acc[row] += 128'(entry_of(row, a)) * 128'(p[a]);
			end
			for (int a = 0; a < 3; a++) begin
				v = project_axis(acc[a], acc[3], fault);
				if (k == 0 || v < bmin[a]) bmin[a] = v;
				if (k == 0 || v > bmax[a]) bmax[a] = v;
			end
		end
		r.out_min_x = bmin[0]; r.out_min_y = bmin[1]; r.out_min_z = bmin[2];
		r.out_max_x = bmax[0]; r.out_max_y = bmax[1]; r.out_max_z = bmax[2];
		r.w_fault = fault;
		return r;
	endfunction

	// Driver: the predictor runs at acceptance, so the matrix in force is the one used.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_in.valid <= 0;
			box_in.box <= '0;
		end else begin
			if (box_in.valid && box_in.ready) begin
				expected_boxes.push_back(transform_box(box_in.box));
				void'(pending_boxes.pop_front());
				boxes_sent++;
			end
			if ((!box_in.valid || box_in.ready) && pending_boxes.size() > 0) begin
				if (box_in.valid && box_in.ready && pending_boxes.size() == 0) begin
					box_in.valid <= 0;
				end else if (idle_on && $urandom_range(99) < 27) begin
					box_in.valid <= 0;
				end else begin
					box_in.valid <= 1;
					box_in.box <= pending_boxes[0];
				end
			end else if (box_in.valid && box_in.ready) begin
				box_in.valid <= 0;
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			box_out.ready <= 0;
		end else begin
			if (box_out.valid && box_out.ready) begin
				got = box_out.res;
				if (expected_boxes.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = expected_boxes.pop_front();
					boxes_checked++;
					if (got.w_fault) faults_seen++;
					if (got.out_min_x !== want.out_min_x)
						$display("%0t: out_min_x exp %h got %h", $time, want.out_min_x, got.out_min_x);
					if (got.out_min_y !== want.out_min_y)
						$display("%0t: out_min_y exp %h got %h", $time, want.out_min_y, got.out_min_y);
					if (got.out_min_z !== want.out_min_z)
						$display("%0t: out_min_z exp %h got %h", $time, want.out_min_z, got.out_min_z);
					if (got.out_max_x !== want.out_max_x)
						$display("%0t: out_max_x exp %h got %h", $time, want.out_max_x, got.out_max_x);
					if (got.out_max_y !== want.out_max_y)
						$display("%0t: out_max_y exp %h got %h", $time, want.out_max_y, got.out_max_y);
					if (got.out_max_z !== want.out_max_z)
						$display("%0t: out_max_z exp %h got %h", $time, want.out_max_z, got.out_max_z);
					if (got.w_fault !== want.w_fault)
						$display("%0t: w_fault exp %b got %b", $time, want.w_fault, got.w_fault);
					if (got !== want) errors++;
				end
			end
			if (hold_out) begin
				hold_cycles <= hold_cycles + 1;
				box_out.ready <= 0;
			end else begin
				hold_cycles <= 0;
				box_out.ready <= !(idle_on && $urandom_range(99) < 27);
			end
		end
	end

	task automatic write_reg(int idx, logic [RW-1:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= IW'(idx);
		cfg_data <= value;
		if (idx < NREG) matrix_regs[idx] = value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain_all();
		while (pending_boxes.size() > 0 || box_in.valid || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 32'h0008_0000)) - coord_t'(32'h0004_0000);
			default: return coord_t'($urandom_range(0, 32'h0200_0000)) - coord_t'(32'h0100_0000);
		endcase
	endfunction

	task automatic add_random_boxes(int count);
		box_t b;
		int mode;
		repeat (count) begin
			mode = $urandom_range(0, 3);
			b.min_x = rand_coord(mode); b.min_y = rand_coord(mode);
			b.min_z = rand_coord(mode); b.max_x = rand_coord(mode);
			b.max_y = rand_coord(mode); b.max_z = rand_coord(mode);
			pending_boxes.push_back(b);
		end
	endtask

	// Entries mostly moderate with a random w row; sometimes fully random words.
	function automatic logic [RW-1:0] rand_reg_word(bit wild);
		logic [31:0] a;
		logic [31:0] c;
		if (wild) return {$urandom, $urandom};
		a = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
		c = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
		return {c, a};
	endfunction

	function automatic box_t make_box(coord_t a, coord_t b);
		box_t x;
		x.min_x = a; x.min_y = a; x.min_z = a;
		x.max_x = b; x.max_y = b; x.max_z = b;
		return x;
	endfunction

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		box_out.ready = 0;
		box_in.valid = 0;
		box_in.box = '0;
		for (int i = 0; i < NREG; i++) matrix_regs[i] = REG_RESET[i];
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity, extremes, inverted box.
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		pending_boxes.push_back(make_box(COORD_MAX, COORD_MIN));
		pending_boxes.push_back(make_box('0, '0));
		pending_boxes.push_back(make_box(32'sh0001_0000, -32'sh0002_8000));
		pending_boxes.push_back(make_box(-1, 1));
		drain_all();

		// Scale x and y by 2 and z by -2 with translation, negative w, and a write beyond the registers.
		write_reg(REG_ROW0_LEFT, 64'h0000_0000_0002_0000);
		write_reg(REG_ROW0_RIGHT, 64'h0003_0000_0000_0000);
		write_reg(REG_ROW1_LEFT, 64'h0002_0000_0000_0000);
		write_reg(REG_ROW1_RIGHT, 64'hFFFF_0000_0000_0000);
		write_reg(REG_ROW2_LEFT, 64'h0);
		write_reg(REG_ROW2_RIGHT, 64'h0000_0000_FFFE_0000);
		write_reg(REG_ROW3_LEFT, 64'h0);
		write_reg(REG_ROW3_RIGHT, 64'hFFFF_0000_0000_0000);
		write_reg(REG_BEYOND, 64'hFFFF_FFFF_FFFF_FFFF);
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		pending_boxes.push_back(make_box(-32'sh0001_0000, 32'sh0004_0000));
		pending_boxes.push_back(make_box(32'sh7000_0000, -32'sh7000_0000));
		drain_all();
		// w = x: zero at x = 0, sign flips across it.
		write_reg(REG_ROW3_LEFT, 64'h0000_0000_0001_0000);
		write_reg(REG_ROW3_RIGHT, 64'h0);
		pending_boxes.push_back(make_box('0, 32'sh0002_0000));
		pending_boxes.push_back(make_box(-32'sh0002_0000, 32'sh0002_0000));
		pending_boxes.push_back(make_box(COORD_MIN, '0));
		drain_all();
		// All-zero matrix: every quotient is zero over zero.
		for (int i = 0; i < NREG; i++) write_reg(i, '0);
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		drain_all();
		// All-ones and extreme words.
		for (int i = 0; i < NREG; i++) write_reg(i, '1);
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		pending_boxes.push_back(make_box(32'sh0000_0100, -32'sh0000_0100));
		drain_all();
		for (int i = 0; i < NREG; i++) write_reg(i, {2{32'h8000_0000}});
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		pending_boxes.push_back(make_box(32'sh0001_0000, 32'sh0002_0000));
		drain_all();
		for (int i = 0; i < NREG; i++) write_reg(i, {2{32'h7FFF_FFFF}});
		pending_boxes.push_back(make_box(COORD_MIN, COORD_MAX));
		drain_all();

		// Back-pressure: receiver holds off while the sender keeps offering.
		for (int i = 0; i < NREG; i++) write_reg(i, REG_RESET[i]);
		idle_on = 0;
		hold_out = 1;
		add_random_boxes(40);
		wait (hold_cycles >= 300);
		hold_out = 0;
		drain_all();

		// Random phases with varied matrices; one phase without idling.
		for (int phase = 0; phase < 12; phase++) begin
			idle_on = (phase != 3);
			for (int i = 0; i < NREG; i++)
				write_reg(i, (i % 2 == 1 && i != 7 && $urandom_range(1)) ? '0 :
					rand_reg_word($urandom_range(0, 5) == 0));
			if (phase % 4 == 1) write_reg(REG_ROW3_LEFT, '0);
			if (phase % 4 == 1) write_reg(REG_ROW3_RIGHT, 64'h0001_0000_0000_0000);
			add_random_boxes(120);
			drain_all();
		end
		idle_on = 1;

		$display("Checked %0d of %0d boxes over 8 directed and 12 random matrices, %0d with w faults.",
			boxes_checked, boxes_sent, faults_seen);
		if (errors == 0 && expected_boxes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tbb_pkg.sv
rtl/core/tbb_if.sv
rtl/core/transform_bounding_box.sv
tb/tb_transform_bounding_box.sv
